@@ hw/rtl/gcmd_pkg.sv @@
// ----------------------------------------------------------------------------
// gcmd_pkg
// Shared types, constants and width helpers for the Manhattan-order grid
// address generator.
// ----------------------------------------------------------------------------
package gcmd_pkg;

	// default largest grid dimension
	localparam int GCMD_MAX_DIM = 256;
	// largest value a 9-bit size register can hold
	localparam int GCMD_SIZE_MAX = 511;
	// apb address width: four 32-bit registers
	localparam int GCMD_AW = 4;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_GRID_ROWS  = 2'd0;
	localparam logic [1:0] REG_GRID_COLS  = 2'd1;
	localparam logic [1:0] REG_CENTER_ROW = 2'd2;
	localparam logic [1:0] REG_CENTER_COL = 2'd3;

	// candidate order within one offset pair
	localparam logic [1:0] QD_UP_LEFT    = 2'd0;
	localparam logic [1:0] QD_UP_RIGHT   = 2'd1;
	localparam logic [1:0] QD_DOWN_RIGHT = 2'd2;
	localparam logic [1:0] QD_DOWN_LEFT  = 2'd3;

	// effective dimension limit after saturation
	function automatic int gcmd_eff_max(input int max_dim);
		return (max_dim < GCMD_SIZE_MAX) ? max_dim : GCMD_SIZE_MAX;
	endfunction

	// bits for a coordinate 0 .. eff_max-1
	function automatic int gcmd_coord_w(input int max_dim);
		return $clog2(gcmd_eff_max(max_dim));
	endfunction

	// bits for a distance 0 .. 2*eff_max-1 (one past the largest distance)
	function automatic int gcmd_dist_w(input int max_dim);
		return $clog2(2 * gcmd_eff_max(max_dim));
	endfunction

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEEK1,
		ST_SEEK2,
		ST_EMIT
	} gcmd_state_t;

	// controller to datapath commands
	typedef struct packed {
		logic start;      // clear the walk position, mark active
		logic step;       // move past a candidate that is not in the grid
		logic adv;        // move past the emitted candidate
		logic deact;      // walk finished
		logic res_cap;    // capture the current candidate as the result
		logic res_none;   // result is an empty word
		logic set_last;   // mark the captured result as the final cell
		logic load_out;   // move the result into the output register
	} gcmd_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic active;     // walk in progress
		logic over;       // position lies past the largest distance
		logic found;      // current candidate lies in the grid
		logic out_busy;   // output register full and not taken this cycle
	} gcmd_sts_t;

endpackage

@@ hw/rtl/gcmd_req_if.sv @@
// ----------------------------------------------------------------------------
// gcmd_req_if
// Request channel: one word asks for the next cell or restarts the walk.
// ----------------------------------------------------------------------------
interface gcmd_req_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

@@ hw/rtl/gcmd_res_if.sv @@
// ----------------------------------------------------------------------------
// gcmd_res_if
// Result channel: one word per request, carrying the cell and its distance.
// ----------------------------------------------------------------------------
interface gcmd_res_if;
	logic       valid;
	logic       ready;
	logic       valid_res;
	logic [7:0] cell_row;
	logic [7:0] cell_col;
	logic [8:0] distance;
	logic       last;

	modport source (
		output valid, output valid_res, output cell_row, output cell_col,
		output distance, output last, input ready
	);
	modport sink (
		input valid, input valid_res, input cell_row, input cell_col,
		input distance, input last, output ready
	);
endinterface

@@ hw/rtl/gcmd_cfg.sv @@
// ----------------------------------------------------------------------------
// gcmd_cfg
// APB register file plus saturation of grid size and center, and the
// per-axis and total reach of the walk.
// ----------------------------------------------------------------------------
module gcmd_cfg import gcmd_pkg::*; #(
	parameter int MAX_DIM = GCMD_MAX_DIM
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [GCMD_AW-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output logic [gcmd_coord_w(MAX_DIM)-1:0] r0,
	output logic [gcmd_coord_w(MAX_DIM)-1:0] c0,
	output logic [gcmd_coord_w(MAX_DIM)-1:0] drh,
	output logic [gcmd_coord_w(MAX_DIM)-1:0] dcr,
	output logic [gcmd_coord_w(MAX_DIM)-1:0] dr,
	output logic [gcmd_coord_w(MAX_DIM)-1:0] dc,
	output logic [gcmd_dist_w(MAX_DIM)-1:0]  dmax
);

	localparam int EFF_MAX = gcmd_eff_max(MAX_DIM);
	localparam int CW = gcmd_coord_w(MAX_DIM);
	localparam int DW = gcmd_dist_w(MAX_DIM);

	logic [8:0] rows_q, cols_q;
	logic [7:0] crow_q, ccol_q;
	logic       wr_en;
	logic [CW-1:0] rm1, cm1;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 9'd1;
			cols_q <= 9'd1;
			crow_q <= 8'd0;
			ccol_q <= 8'd0;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_GRID_ROWS:  rows_q <= pwdata[8:0];
				REG_GRID_COLS:  cols_q <= pwdata[8:0];
				REG_CENTER_ROW: crow_q <= pwdata[7:0];
				REG_CENTER_COL: ccol_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		unique case (paddr[3:2])
			REG_GRID_ROWS:  prdata = {23'd0, rows_q};
			REG_GRID_COLS:  prdata = {23'd0, cols_q};
			REG_CENTER_ROW: prdata = {24'd0, crow_q};
			REG_CENTER_COL: prdata = {24'd0, ccol_q};
			default:        prdata = '0;
		endcase
	end

	// last row and column index after size saturation
	always_comb begin
		if (rows_q == 9'd0)
			rm1 = '0;
		else if (int'(rows_q) > EFF_MAX)
			rm1 = CW'(EFF_MAX - 1);
		else
			rm1 = CW'(rows_q - 9'd1);
		if (cols_q == 9'd0)
			cm1 = '0;
		else if (int'(cols_q) > EFF_MAX)
			cm1 = CW'(EFF_MAX - 1);
		else
			cm1 = CW'(cols_q - 9'd1);
	end

	// center saturated into the grid
	assign r0 = (int'(crow_q) > int'(rm1)) ? rm1 : CW'(crow_q);
	assign c0 = (int'(ccol_q) > int'(cm1)) ? cm1 : CW'(ccol_q);

	// reach below / right of center, farthest reach per axis, walk extent
	assign drh  = rm1 - r0;
	assign dcr  = cm1 - c0;
	assign dr   = (drh > r0) ? drh : r0;
	assign dc   = (dcr > c0) ? dcr : c0;
	assign dmax = DW'(dr) + DW'(dc);

endmodule

@@ hw/rtl/gcmd_ctrl.sv @@
// ----------------------------------------------------------------------------
// gcmd_ctrl
// Controller: takes a request word, runs the datapath through the search for
// the cell to give and the search for the one after it, then hands the
// result word to the output register.
// ----------------------------------------------------------------------------
module gcmd_ctrl import gcmd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_restart,
	output logic      in_ready,
	input  gcmd_sts_t sts,
	output gcmd_cmd_t cmd
);

	gcmd_state_t state_q, state_nx;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nx;
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_nx = ST_SEEK1;
			end
			ST_SEEK1: begin
				if (!sts.active || sts.over)
					state_nx = ST_EMIT;
				else if (sts.found)
					state_nx = ST_SEEK2;
			end
			ST_SEEK2: begin
				if (sts.over || sts.found)
					state_nx = ST_EMIT;
			end
			ST_EMIT: begin
				if (!sts.out_busy)
					state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.start = in_valid && in_restart;
			end
			ST_SEEK1: begin
				if (!sts.active) begin
					cmd.res_none = 1'b1;
				end else if (sts.over) begin
					cmd.res_none = 1'b1;
					cmd.deact    = 1'b1;
				end else if (sts.found) begin
					cmd.res_cap = 1'b1;
					cmd.adv     = 1'b1;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_SEEK2: begin
				if (sts.over) begin
					cmd.deact    = 1'b1;
					cmd.set_last = 1'b1;
				end else if (!sts.found) begin
					cmd.step = 1'b1;
				end
			end
			ST_EMIT: begin
				cmd.load_out = !sts.out_busy;
			end
			default: ;
		endcase
	end

endmodule

@@ hw/rtl/gcmd_dp.sv @@
// ----------------------------------------------------------------------------
// gcmd_dp
// Datapath: walk position (distance, row offset, quadrant), candidate test
// against the grid, result staging and the output register.
// ----------------------------------------------------------------------------
module gcmd_dp import gcmd_pkg::*; #(
	parameter int MAX_DIM = GCMD_MAX_DIM
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic [gcmd_coord_w(MAX_DIM)-1:0] r0,
	input  logic [gcmd_coord_w(MAX_DIM)-1:0] c0,
	input  logic [gcmd_coord_w(MAX_DIM)-1:0] drh,
	input  logic [gcmd_coord_w(MAX_DIM)-1:0] dcr,
	input  logic [gcmd_coord_w(MAX_DIM)-1:0] dr,
	input  logic [gcmd_coord_w(MAX_DIM)-1:0] dc,
	input  logic [gcmd_dist_w(MAX_DIM)-1:0]  dmax,
	input  gcmd_cmd_t cmd,
	output gcmd_sts_t sts,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       out_valid_res,
	output logic [7:0] out_cell_row,
	output logic [7:0] out_cell_col,
	output logic [8:0] out_distance,
	output logic       out_last
);

	localparam int CW = gcmd_coord_w(MAX_DIM);
	localparam int DW = gcmd_dist_w(MAX_DIM);

	// walk position
	logic [DW-1:0] d_q, i_q;
	logic [1:0]    qd_q;
	logic          active_q;

	// candidate evaluation
	logic [DW-1:0] j;
	logic          j_ok, i_nz, j_nz;
	logic          up_ok, down_ok, left_ok, right_ok;
	logic          found;
	logic [CW-1:0] cand_row, cand_col;

	// next position
	logic [DW-1:0] d_nx, i_nx;
	logic [1:0]    qd_nx;
	logic [DW-1:0] adv_d, adv_i;
	logic [1:0]    adv_qd;

	// result staging and output register
	logic          res_valid_q, res_last_q;
	logic [CW-1:0] res_row_q, res_col_q;
	logic [DW-1:0] res_dist_q;
	logic          out_valid_q, out_valid_res_q, out_last_q;
	logic [7:0]    out_row_q, out_col_q;
	logic [8:0]    out_dist_q;

	// candidate in grid
	assign j        = d_q - i_q;
	assign j_ok     = i_q <= d_q;
	assign i_nz     = i_q != '0;
	assign j_nz     = j != '0;
	assign up_ok    = i_q <= DW'(r0);
	assign down_ok  = i_q <= DW'(drh);
	assign left_ok  = j <= DW'(c0);
	assign right_ok = j <= DW'(dcr);

	always_comb begin
		case (qd_q)
			QD_UP_LEFT:    found = up_ok && left_ok;
			QD_UP_RIGHT:   found = j_nz && up_ok && right_ok;
			QD_DOWN_RIGHT: found = i_nz && down_ok && right_ok;
			default:       found = i_nz && j_nz && down_ok && left_ok;
		endcase
		found = found && j_ok;
	end

	assign cand_row = qd_q[1] ? (r0 + CW'(i_q)) : (r0 - CW'(i_q));
	assign cand_col = (qd_q == QD_UP_LEFT || qd_q == QD_DOWN_LEFT) ?
		(c0 - CW'(j)) : (c0 + CW'(j));

	// plain advance: next quadrant, then next offset, then next distance
	always_comb begin
		adv_d  = d_q;
		adv_i  = i_q;
		adv_qd = qd_q + 2'd1;
		if (qd_q == QD_DOWN_LEFT) begin
			if (i_q >= d_q) begin
				adv_i = '0;
				adv_d = d_q + DW'(1);
			end else begin
				adv_i = i_q + DW'(1);
			end
		end
	end

	// skip: whole rows out of reach end the distance, whole columns out of
	// reach jump to the first offset whose column can be in the grid
	always_comb begin
		d_nx  = d_q;
		i_nx  = i_q;
		qd_nx = qd_q;
		if (cmd.start) begin
			d_nx  = '0;
			i_nx  = '0;
			qd_nx = QD_UP_LEFT;
		end else if (cmd.step) begin
			if (i_q > DW'(dr)) begin
				d_nx  = d_q + DW'(1);
				i_nx  = '0;
				qd_nx = QD_UP_LEFT;
			end else if (j_ok && j > DW'(dc)) begin
				i_nx  = d_q - DW'(dc);
				qd_nx = QD_UP_LEFT;
			end else begin
				d_nx  = adv_d;
				i_nx  = adv_i;
				qd_nx = adv_qd;
			end
		end else if (cmd.adv) begin
			d_nx  = adv_d;
			i_nx  = adv_i;
			qd_nx = adv_qd;
		end
	end

	// position and walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q      <= '0;
			i_q      <= '0;
			qd_q     <= QD_UP_LEFT;
			active_q <= 1'b0;
		end else begin
			d_q  <= d_nx;
			i_q  <= i_nx;
			qd_q <= qd_nx;
			if (cmd.start)
				active_q <= 1'b1;
			else if (cmd.deact)
				active_q <= 1'b0;
		end
	end

	// result staging
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			res_last_q  <= 1'b0;
		end else if (cmd.res_none) begin
			res_valid_q <= 1'b0;
			res_last_q  <= 1'b0;
		end else if (cmd.res_cap) begin
			res_valid_q <= 1'b1;
			res_last_q  <= 1'b0;
		end else if (cmd.set_last) begin
			res_last_q  <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_none) begin
			res_row_q  <= '0;
			res_col_q  <= '0;
			res_dist_q <= '0;
		end else if (cmd.res_cap) begin
			res_row_q  <= cand_row;
			res_col_q  <= cand_col;
			res_dist_q <= d_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_valid_res_q <= res_valid_q;
			out_last_q      <= res_last_q;
			out_row_q       <= 8'(res_row_q);
			out_col_q       <= 8'(res_col_q);
			out_dist_q      <= 9'(res_dist_q);
		end
	end

	assign out_valid     = out_valid_q;
	assign out_valid_res = out_valid_res_q;
	assign out_cell_row  = out_row_q;
	assign out_cell_col  = out_col_q;
	assign out_distance  = out_dist_q;
	assign out_last      = out_last_q;

	// status
	assign sts.active   = active_q;
	assign sts.over     = d_q > dmax;
	assign sts.found    = found;
	assign sts.out_busy = out_valid_q && !out_ready;

endmodule

@@ hw/rtl/grid_cells_by_manhattan_distance_unit.sv @@
// ----------------------------------------------------------------------------
// grid_cells_by_manhattan_distance_unit
// Walks every cell of a rows-by-cols grid in rising Manhattan distance from
// a configured center, one cell per request word.
//
// Channels: req (restart bit) in, res (valid_res, cell_row, cell_col,
// distance, last) out, valid/ready on both. Every request gives exactly one
// result word. restart=1 begins at the center and gives the center cell;
// restart=0 gives the next cell, or valid_res=0 before a start and after the
// final cell (that word carries last=1).
// Grid size and center are set over the APB port (rows, cols, center row,
// center col at byte offsets 0, 4, 8, 12); the user must write them only
// while the unit is idle, as the block itself does not enforce this. The
// candidate search tests one position per cycle in the datapath; a new
// request is taken only once the previous result has moved into the output
// register.
// Reset: registers go to a 1x1 grid centered at 0, no walk in progress.
// Stall: the result waits in the output register; a new request is taken
// meanwhile and its result waits in the datapath until the register frees.
// ----------------------------------------------------------------------------
module grid_cells_by_manhattan_distance_unit import gcmd_pkg::*; #(
	parameter int MAX_DIM = GCMD_MAX_DIM
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [GCMD_AW-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	gcmd_req_if.sink           req,
	gcmd_res_if.source         res
);

	localparam int CW = gcmd_coord_w(MAX_DIM);
	localparam int DW = gcmd_dist_w(MAX_DIM);

	logic [CW-1:0] r0, c0, drh, dcr, dr, dc;
	logic [DW-1:0] dmax;
	gcmd_cmd_t     cmd;
	gcmd_sts_t     sts;

	// configuration registers
	gcmd_cfg #(.MAX_DIM(MAX_DIM)) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.r0      (r0),
		.c0      (c0),
		.drh     (drh),
		.dcr     (dcr),
		.dr      (dr),
		.dc      (dc),
		.dmax    (dmax)
	);

	// controller
	gcmd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (req.valid),
		.in_restart (req.restart),
		.in_ready   (req.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	// datapath
	gcmd_dp #(.MAX_DIM(MAX_DIM)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.r0            (r0),
		.c0            (c0),
		.drh           (drh),
		.dcr           (dcr),
		.dr            (dr),
		.dc            (dc),
		.dmax          (dmax),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (res.valid),
		.out_ready     (res.ready),
		.out_valid_res (res.valid_res),
		.out_cell_row  (res.cell_row),
		.out_cell_col  (res.cell_col),
		.out_distance  (res.distance),
		.out_last      (res.last)
	);

endmodule

@@ verif/manhattan_walk_checker.sv @@
// ----------------------------------------------------------------------------
// manhattan_walk_checker
// Watches the register port and both word channels of the grid address
// generator. It keeps its own copy of the registers and of the walk position,
// predicts the result word for every accepted request, and compares each
// accepted result word against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module manhattan_walk_checker import gcmd_pkg::*; #(
	parameter int MAX_DIM = GCMD_MAX_DIM
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [GCMD_AW-1:0] paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	gcmd_req_if                req,
	gcmd_res_if                res,
	output int                 fail_count,
	output int                 pending,
	output int                 cells_seen,
	output int                 ends_seen,
	output int                 lasts_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic       valid_res;
		logic [7:0] row;
		logic [7:0] col;
		logic [8:0] distance;
		logic       last;
	} cell_word_t;

	// register copy
	logic [8:0] cfg_rows;
	logic [8:0] cfg_cols;
	logic [7:0] cfg_crow;
	logic [7:0] cfg_ccol;

	// walk position
	int         walk_dist;
	int         walk_ofs;
	logic [1:0] walk_quad;
	bit         walk_on;

	cell_word_t cells_due[$];
	int         mismatches;
	int         n_cells;
	int         n_ends;
	int         n_lasts;
	int         word_idx;

	// size register clipped to 1 .. MAX_DIM
	function automatic int clip_dim(input int v);
		if (v < 1)
			v = 1;
		if (v > MAX_DIM)
			v = MAX_DIM;
		return v;
	endfunction

	// center clipped to the last row or column
	function automatic int clip_center(input int c, input int dim);
		return (c > dim - 1) ? dim - 1 : c;
	endfunction

	function automatic int farthest_distance();
		int rows, cols, r0, c0, dr, dc;
		rows = clip_dim(int'(cfg_rows));
		cols = clip_dim(int'(cfg_cols));
		r0 = clip_center(int'(cfg_crow), rows);
		c0 = clip_center(int'(cfg_ccol), cols);
		dr = (rows - 1 - r0 > r0) ? rows - 1 - r0 : r0;
		dc = (cols - 1 - c0 > c0) ? cols - 1 - c0 : c0;
		return dr + dc;
	endfunction

	// candidate at the current position, 1 if it exists and lies in the grid
	function automatic bit probe_cell(output int r, output int c);
		int rows, cols, r0, c0, i, j;
		rows = clip_dim(int'(cfg_rows));
		cols = clip_dim(int'(cfg_cols));
		r0 = clip_center(int'(cfg_crow), rows);
		c0 = clip_center(int'(cfg_ccol), cols);
		i = walk_ofs;
		j = walk_dist - walk_ofs;
		r = 0;
		c = 0;
		if (j < 0)
			return 0;
		case (walk_quad)
			QD_UP_LEFT: begin
				r = r0 - i;
				c = c0 - j;
			end
			QD_UP_RIGHT: begin
				if (j == 0)
					return 0;
				r = r0 - i;
				c = c0 + j;
			end
			QD_DOWN_RIGHT: begin
				if (i == 0)
					return 0;
				r = r0 + i;
				c = c0 + j;
			end
			default: begin
				if (i == 0 || j == 0)
					return 0;
				r = r0 + i;
				c = c0 - j;
			end
		endcase
		return (r >= 0 && r < rows && c >= 0 && c < cols);
	endfunction

	// next candidate: quadrant, then row offset, then distance
	function automatic void step_position();
		walk_quad = walk_quad + 2'd1;
		if (walk_quad == QD_UP_LEFT) begin
			walk_ofs++;
			if (walk_ofs > walk_dist) begin
				walk_ofs = 0;
				walk_dist++;
			end
		end
	endfunction

	// first in-grid cell at or after the current position
	function automatic bit seek_cell(output int r, output int c);
		int dmax;
		dmax = farthest_distance();
		r = 0;
		c = 0;
		while (walk_dist <= dmax) begin
			if (probe_cell(r, c))
				return 1;
			step_position();
		end
		return 0;
	endfunction

	// result word for one request, advancing the walk
	function automatic cell_word_t predict_cell_word(input logic restart);
		cell_word_t w;
		int r, c, nr, nc, d;
		w = '0;
		if (restart) begin
			walk_dist = 0;
			walk_ofs = 0;
			walk_quad = QD_UP_LEFT;
			walk_on = 1;
		end
		if (!walk_on)
			return w;
		if (!seek_cell(r, c)) begin
			walk_on = 0;
			return w;
		end
		d = walk_dist;
		step_position();
		if (!seek_cell(nr, nc)) begin
			walk_on = 0;
			w.last = 1'b1;
		end
		w.valid_res = 1'b1;
		w.row = r[7:0];
		w.col = c[7:0];
		w.distance = d[8:0];
		return w;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t ns: result word %0d: %s is %0d, expected %0d",
			$time, word_idx, what, got, want);
		mismatches++;
	endtask

	// register writes, result checks, then new predictions
	always @(posedge clk or negedge arst_n) begin
		cell_word_t exp_w;
		if (!arst_n) begin
			cfg_rows = 9'd1;
			cfg_cols = 9'd1;
			cfg_crow = 8'd0;
			cfg_ccol = 8'd0;
			walk_dist = 0;
			walk_ofs = 0;
			walk_quad = QD_UP_LEFT;
			walk_on = 0;
			cells_due.delete();
			mismatches = 0;
			n_cells = 0;
			n_ends = 0;
			n_lasts = 0;
			word_idx = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_GRID_ROWS:  cfg_rows = pwdata[8:0];
					REG_GRID_COLS:  cfg_cols = pwdata[8:0];
					REG_CENTER_ROW: cfg_crow = pwdata[7:0];
					default:        cfg_ccol = pwdata[7:0];
				endcase
			end
			if (res.valid && res.ready) begin
				if (cells_due.size() == 0) begin
					report_mismatch("unexpected word, pending count", 1, 0);
				end else begin
					exp_w = cells_due.pop_front();
					if (res.valid_res !== exp_w.valid_res)
						report_mismatch("valid_res", int'(res.valid_res),
							int'(exp_w.valid_res));
					if (res.cell_row !== exp_w.row)
						report_mismatch("cell_row", int'(res.cell_row), int'(exp_w.row));
					if (res.cell_col !== exp_w.col)
						report_mismatch("cell_col", int'(res.cell_col), int'(exp_w.col));
					if (res.distance !== exp_w.distance)
						report_mismatch("distance", int'(res.distance),
							int'(exp_w.distance));
					if (res.last !== exp_w.last)
						report_mismatch("last", int'(res.last), int'(exp_w.last));
					if (exp_w.valid_res)
						n_cells++;
					else
						n_ends++;
					if (exp_w.last)
						n_lasts++;
				end
				word_idx++;
			end
			if (req.valid && req.ready)
				cells_due.push_back(predict_cell_word(req.restart));
		end
		pending <= cells_due.size();
		fail_count <= mismatches;
		cells_seen <= n_cells;
		ends_seen <= n_ends;
		lasts_seen <= n_lasts;
	end

endmodule

@@ verif/grid_cells_by_manhattan_distance_unit_test.sv @@
// ----------------------------------------------------------------------------
// grid_cells_by_manhattan_distance_unit_test
// Drives the grid address generator through register settings and request
// words: a short directed part for the corner cases, then phases of random
// grid geometry with mostly complete walks, random idling on both channels
// and one long result stall. The checker beside the block does all checking.
// ----------------------------------------------------------------------------
module grid_cells_by_manhattan_distance_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import gcmd_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [GCMD_AW-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	gcmd_req_if req ();
	gcmd_res_if res ();

	int fail_count;
	int pending;
	int cells_seen;
	int ends_seen;
	int lasts_seen;

	// stimulus state; quiet and hold_off_pending are shared with the receiver process
	bit quiet;
	bit steady;
	bit hold_off_pending;
	int requests_sent;
	int random_items;
	int settings_used;

	int rows;
	int cols;
	int crow;
	int ccol;
	int n_items;
	int sel;
	bit fresh;

	grid_cells_by_manhattan_distance_unit uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req.sink),
		.res     (res.source)
	);

	manhattan_walk_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.req        (req),
		.res        (res),
		.fail_count (fail_count),
		.pending    (pending),
		.cells_seen (cells_seen),
		.ends_seen  (ends_seen),
		.lasts_seen (lasts_seen)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	initial begin
		#3_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// apb write: setup cycle, access cycle, then idle
	task automatic set_register(input logic [1:0] index, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_grid(input int nr, input int nc, input int r0, input int c0);
		set_register(REG_GRID_ROWS, 32'(nr));
		set_register(REG_GRID_COLS, 32'(nc));
		set_register(REG_CENTER_ROW, 32'(r0));
		set_register(REG_CENTER_COL, 32'(c0));
		settings_used++;
	endtask

	// one request word, with an optional idle burst ahead of it
	task automatic request_cell(input bit restart);
		int gap;
		gap = 0;
		if (!quiet && !steady && $urandom_range(0, 99) < 30)
			gap = $urandom_range(1, 14);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.restart <= restart;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		requests_sent++;
	endtask

	// stop offering and wait until every expected word is back
	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// result receiver: random stalls, one long hold-off on request
	initial begin
		res.ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_off_pending) begin
				hold_off_pending = 0;
				res.ready <= 1'b0;
				repeat (80) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 99) < 30) begin
				res.ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				res.ready <= 1'b1;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end
	end

	initial begin
		req.valid = 1'b0;
		req.restart = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		quiet = 0;
		steady = 0;
		hold_off_pending = 0;
		requests_sent = 0;
		random_items = 0;
		settings_used = 0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk not started, then a one-cell grid and the finished walk
		request_cell(0);
		request_cell(0);
		request_cell(1);
		request_cell(0);
		drain();

		// zero sizes count as one, center saturates
		set_grid(0, 0, 255, 255);
		request_cell(1);
		drain();

		// full walk of a 3x4 grid from an inner center
		set_grid(3, 4, 1, 2);
		request_cell(1);
		repeat (12) request_cell(0);
		drain();

		// geometry changed in the middle of a walk
		set_grid(3, 4, 0, 0);
		request_cell(1);
		request_cell(0);
		drain();
		set_grid(2, 2, 0, 0);
		request_cell(0);
		request_cell(0);
		drain();

		// oversized rows clip to the limit, center at the far corner
		set_grid(511, 256, 255, 255);
		request_cell(1);
		request_cell(0);
		drain();

		// tall single-column grid walked to the end, with the long stall
		set_grid(256, 1, 128, 0);
		hold_off_pending = 1;
		request_cell(1);
		repeat (256) request_cell(0);
		random_items += 257;
		drain();

		// random geometry phases, mostly complete walks
		while (random_items < 1000) begin
			sel = $urandom_range(0, 9);
			if (sel < 7) begin
				rows = $urandom_range(1, 6);
				cols = $urandom_range(1, 6);
				crow = $urandom_range(0, 7);
				ccol = $urandom_range(0, 7);
				n_items = rows * cols + $urandom_range(0, 2);
			end else if (sel < 9) begin
				if ($urandom_range(0, 1)) begin
					rows = $urandom_range(8, 40);
					cols = $urandom_range(1, 3);
				end else begin
					rows = $urandom_range(1, 3);
					cols = $urandom_range(8, 40);
				end
				crow = $urandom_range(0, 45);
				ccol = $urandom_range(0, 45);
				n_items = rows * cols + 1;
			end else begin
				rows = $urandom_range(0, 511);
				cols = $urandom_range(0, 511);
				crow = $urandom_range(0, 255);
				ccol = $urandom_range(0, 255);
				n_items = $urandom_range(1, 6);
			end
			fresh = ($urandom_range(0, 99) < 85);
			if (!fresh)
				n_items = $urandom_range(1, 8);
			steady = ($urandom_range(0, 3) == 0);
			set_grid(rows, cols, crow, ccol);
			for (int k = 0; k < n_items; k++) begin
				request_cell((k == 0 && fresh) || $urandom_range(0, 39) == 0);
				random_items++;
				if (random_items >= 850)
					quiet = 1;
			end
			drain();
		end

		// final drain and settle
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("%0d requests over %0d grid settings: %0d cells, %0d final cells",
			requests_sent, settings_used, cells_seen, lasts_seen);
		$display("%0d empty words before a start or after a finished walk", ends_seen);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
